[rtl/core/kmu_pkg.sv]
`timescale 1ns / 1ps
// Shared types, widths and codes for the online k-means block.
// No dependencies.
package kmu_pkg;

  localparam int MAX_CLUSTERS = 8;
  localparam int MAX_DIMS     = 4;
  localparam int MAX_POINTS   = 1024;

  localparam int CL_W    = $clog2(MAX_CLUSTERS);
  localparam int DIM_W   = $clog2(MAX_DIMS);
  localparam int PT_W    = $clog2(MAX_POINTS);
  localparam int K_W     = 4;
  localparam int D_W     = 3;
  localparam int COORD_W = 16;
  localparam int FX_W    = 24;
  localparam int FRAC_W  = 8;
  localparam int CNT_W   = 16;
  localparam int DIFF_W  = FX_W + 1;
  localparam int SQ_W    = 2 * FX_W + 1;
  localparam int DIST_W  = SQ_W + 2;
  localparam int NUM_W   = FX_W + CNT_W + 1;
  localparam int DIVC_W  = $clog2(NUM_W + 1);
  localparam int CFG_W   = 2;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  localparam logic [1:0] ACT_LOAD  = 2'd0;
  localparam logic [1:0] ACT_TRAIN = 2'd1;
  localparam logic [1:0] ACT_CLASS = 2'd2;
  localparam logic [1:0] ACT_NOP   = 2'd3;

  localparam logic [CFG_W-1:0] REG_CLUSTERS = 2'd0;
  localparam logic [CFG_W-1:0] REG_DIMS     = 2'd1;

  typedef struct packed {
    logic [1:0]                action;
    logic [2:0]                centroid_index;
    logic [9:0]                point_index;
    logic signed [COORD_W-1:0] coord_0;
    logic signed [COORD_W-1:0] coord_1;
    logic signed [COORD_W-1:0] coord_2;
    logic signed [COORD_W-1:0] coord_3;
  } kmu_in_t;

  typedef struct packed {
    logic [2:0]       cluster;
    logic             changed;
    logic [CNT_W-1:0] cluster_count;
  } kmu_out_t;

  typedef logic [MAX_DIMS-1:0][FX_W-1:0] kmu_vec_t;

  typedef struct packed {
    logic [DIST_W-1:0] score;
    logic [CL_W-1:0]   idx;
  } kmu_best_t;

  typedef struct packed {
    logic [K_W-1:0]        k;
    logic                  acc_clr;
    logic                  dist_en;
    logic [DIM_W-1:0]      dim;
    logic signed [FX_W-1:0] pt;
    logic                  ld_en;
    logic [CL_W-1:0]       ld_idx;
    logic                  wr_en;
    logic [CL_W-1:0]       wr_idx;
    logic [DIM_W-1:0]      wr_dim;
    logic [FX_W-1:0]       wr_val;
    logic                  inc_en;
  } kmu_ctl_t;

endpackage

[rtl/core/kmu_cell.sv]
`timescale 1ns / 1ps
// One centroid cell: coordinates, count, distance accumulator, chain stage.
// Depends on kmu_pkg.
module kmu_cell import kmu_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [CL_W-1:0]  cell_id,
  input  kmu_ctl_t         ctl,
  input  kmu_vec_t         ld_vec,
  input  kmu_best_t        best_in,
  output kmu_best_t        best_out,
  output kmu_vec_t         coords,
  output logic [CNT_W-1:0] count
);

  logic [FX_W-1:0]          coord_r [MAX_DIMS];
  logic [CNT_W-1:0]         cnt_r;
  logic signed [DIFF_W-1:0] diff_r;
  logic                     diff_v_r;
  logic [SQ_W-1:0]          sq_r;
  logic                     sq_v_r;
  logic [DIST_W-1:0]        acc_r;
  kmu_best_t                best_r;
  logic signed [2*DIFF_W-1:0] sq_full;
  logic                     mine;

  assign sq_full = diff_r * diff_r;
  assign mine    = (cell_id == '0) ||
                   (({1'b0, cell_id} < ctl.k) && (acc_r < best_in.score));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int d = 0; d < MAX_DIMS; d++) coord_r[d] <= '0;
      cnt_r    <= '0;
      diff_v_r <= 1'b0;
      sq_v_r   <= 1'b0;
    end else begin
      if (ctl.ld_en && ctl.ld_idx == cell_id) begin
        for (int d = 0; d < MAX_DIMS; d++) coord_r[d] <= ld_vec[d];
      end
      if (ctl.wr_en && ctl.wr_idx == cell_id) begin
        coord_r[ctl.wr_dim] <= ctl.wr_val;
      end
      if (ctl.inc_en && ctl.wr_idx == cell_id && cnt_r != CNT_MAX) begin
        cnt_r <= cnt_r + 1'b1;
      end
      diff_v_r <= ctl.dist_en;
      sq_v_r   <= diff_v_r;
    end
  end

  always_ff @(posedge clk) begin
    diff_r <= DIFF_W'(ctl.pt) - DIFF_W'($signed(coord_r[ctl.dim]));
    sq_r   <= sq_full[SQ_W-1:0];
    if (ctl.acc_clr) begin
      acc_r <= '0;
    end else if (sq_v_r) begin
      acc_r <= acc_r + DIST_W'(sq_r);
    end
    if (mine) begin
      best_r.score <= acc_r;
      best_r.idx   <= cell_id;
    end else begin
      best_r <= best_in;
    end
  end

  always_comb begin
    for (int d = 0; d < MAX_DIMS; d++) coords[d] = coord_r[d];
  end
  assign count    = cnt_r;
  assign best_out = best_r;

endmodule

[rtl/core/kmu_div.sv]
`timescale 1ns / 1ps
// Radix-2 restoring divider, signed dividend by unsigned count, truncates to zero.
// Depends on kmu_pkg.
module kmu_div import kmu_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic signed [NUM_W-1:0] num,
  input  logic [CNT_W-1:0]        den,
  output logic                    done,
  output logic [FX_W-1:0]         quo
);

  logic [NUM_W-1:0]  mag_r;
  logic [CNT_W-1:0]  rem_r;
  logic [CNT_W-1:0]  den_r;
  logic              neg_r;
  logic [DIVC_W-1:0] cnt_r;
  logic              busy_r;
  logic              done_r;
  logic [CNT_W:0]    trial;
  logic [CNT_W:0]    shifted;
  logic [NUM_W-1:0]  signed_q;

  assign shifted  = {rem_r, mag_r[NUM_W-1]};
  assign trial    = shifted - {1'b0, den_r};
  assign signed_q = neg_r ? (~mag_r + 1'b1) : mag_r;
  assign quo      = signed_q[FX_W-1:0];
  assign done     = done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == DIVC_W'(1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mag_r <= num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
      neg_r <= num[NUM_W-1];
      den_r <= den;
      rem_r <= '0;
      cnt_r <= DIVC_W'(NUM_W);
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (!trial[CNT_W]) begin
        rem_r <= trial[CNT_W-1:0];
        mag_r <= {mag_r[NUM_W-2:0], 1'b1};
      end else begin
        rem_r <= shifted[CNT_W-1:0];
        mag_r <= {mag_r[NUM_W-2:0], 1'b0};
      end
    end
  end

endmodule

[rtl/core/online_kmeans_update.sv]
`timescale 1ns / 1ps
// Online k-means top level: sequencer, cell row, divider, assignment store.
// Depends on kmu_pkg, kmu_cell, kmu_div.
//
// channel | direction | handshake        | beat
// in_     | input     | in_valid/in_stall   | kmu_in_t
// out_    | output    | out_valid/out_stall | kmu_out_t
// cfg_    | input     | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// Load and the unused action go straight to S_DONE; classify runs the active dims
// through the cell row and drains the chain; train adds a serial division per active dim.
// After reset a pass clears the whole assignment store; in_stall is high meanwhile.
// One item at a time; a result waits in the output register under out_stall.
module online_kmeans_update import kmu_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  kmu_in_t          in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output kmu_out_t         out_data,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CFG_W-1:0] cfg_index,
  input  logic [K_W-1:0]   cfg_data
);

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_DIST  = 4'd2;
  localparam logic [3:0] S_DRAIN = 4'd3;
  localparam logic [3:0] S_CNT   = 4'd4;
  localparam logic [3:0] S_MUL   = 4'd5;
  localparam logic [3:0] S_ADD   = 4'd6;
  localparam logic [3:0] S_DIVS  = 4'd7;
  localparam logic [3:0] S_DIVW  = 4'd8;
  localparam logic [3:0] S_DONE  = 4'd9;

  localparam int DRAIN_CYC = MAX_CLUSTERS + 4;
  localparam int WAIT_W    = $clog2(DRAIN_CYC + 1);

  logic [3:0]        state_r, state_nxt;
  logic [K_W-1:0]    k_raw_r;
  logic [D_W-1:0]    d_raw_r;
  logic [K_W-1:0]    eff_k;
  logic [D_W-1:0]    eff_d;
  logic [1:0]        act_r;
  logic [PT_W-1:0]   pidx_r;
  logic [FX_W-1:0]   pt_r [MAX_DIMS];
  logic [CL_W-1:0]   res_idx_r;
  logic [DIM_W-1:0]  dim_r;
  logic [WAIT_W-1:0] wait_r;
  logic [PT_W-1:0]   clr_r;
  logic [CL_W-1:0]   asg_mem [MAX_POINTS];
  logic [CL_W-1:0]   asg_q_r;
  logic signed [NUM_W-1:0] prod_r;
  logic signed [NUM_W-1:0] num_r;
  logic              out_valid_r;
  kmu_out_t          out_r;
  kmu_ctl_t          ctl;
  kmu_vec_t          ld_vec;
  kmu_best_t         chain [MAX_CLUSTERS+1];
  kmu_vec_t          cell_coords [MAX_CLUSTERS];
  logic [CNT_W-1:0]  cell_cnt [MAX_CLUSTERS];
  logic              accept;
  logic              last_dim;
  logic              emit;
  logic              div_done;
  logic [FX_W-1:0]   div_quo;
  logic signed [FX_W-1:0]  win_coord;
  logic signed [CNT_W:0]   nm1;
  logic [CNT_W-1:0]  sel_cnt;

  assign eff_k = (k_raw_r == '0) ? K_W'(1) :
                 (k_raw_r > K_W'(MAX_CLUSTERS)) ? K_W'(MAX_CLUSTERS) : k_raw_r;
  assign eff_d = (d_raw_r == '0) ? D_W'(1) :
                 (d_raw_r > D_W'(MAX_DIMS)) ? D_W'(MAX_DIMS) : d_raw_r;

  assign accept    = in_valid && !in_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;
  assign last_dim  = ({1'b0, dim_r} == D_W'(eff_d - 1'b1));
  assign emit      = (state_r == S_DONE) && (!out_valid_r || !out_stall);
  assign sel_cnt   = cell_cnt[res_idx_r];
  assign win_coord = $signed(cell_coords[res_idx_r][dim_r]);
  assign nm1       = $signed({1'b0, sel_cnt - 1'b1});

  assign ld_vec[0] = {in_data.coord_0, FRAC_W'(0)};
  assign ld_vec[1] = {in_data.coord_1, FRAC_W'(0)};
  assign ld_vec[2] = {in_data.coord_2, FRAC_W'(0)};
  assign ld_vec[3] = {in_data.coord_3, FRAC_W'(0)};

  always_comb begin
    ctl         = '0;
    ctl.k       = eff_k;
    ctl.dim     = dim_r;
    ctl.pt      = $signed(pt_r[dim_r]);
    ctl.ld_idx  = in_data.centroid_index;
    ctl.wr_idx  = res_idx_r;
    ctl.wr_dim  = dim_r;
    ctl.wr_val  = div_quo;
    ctl.ld_en   = accept && (in_data.action == ACT_LOAD);
    ctl.acc_clr = accept;
    ctl.dist_en = (state_r == S_DIST);
    ctl.inc_en  = (state_r == S_CNT);
    ctl.wr_en   = (state_r == S_DIVW) && div_done;
  end

  assign chain[0] = '0;
  for (genvar c = 0; c < MAX_CLUSTERS; c++) begin : g_cell
    kmu_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cell_id  (CL_W'(c)),
      .ctl      (ctl),
      .ld_vec   (ld_vec),
      .best_in  (chain[c]),
      .best_out (chain[c+1]),
      .coords   (cell_coords[c]),
      .count    (cell_cnt[c])
    );
  end

  kmu_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (state_r == S_DIVS),
    .num   (num_r),
    .den   (sel_cnt),
    .done  (div_done),
    .quo   (div_quo)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: if (clr_r == PT_W'(MAX_POINTS - 1)) state_nxt = S_IDLE;
      S_IDLE: begin
        if (accept) begin
          if (in_data.action == ACT_TRAIN || in_data.action == ACT_CLASS) begin
            state_nxt = S_DIST;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end
      S_DIST:  if (last_dim) state_nxt = S_DRAIN;
      S_DRAIN: if (wait_r == '0) state_nxt = (act_r == ACT_CLASS) ? S_DONE : S_CNT;
      S_CNT:   state_nxt = S_MUL;
      S_MUL:   state_nxt = S_ADD;
      S_ADD:   state_nxt = S_DIVS;
      S_DIVS:  state_nxt = S_DIVW;
      S_DIVW:  if (div_done) state_nxt = last_dim ? S_DONE : S_MUL;
      S_DONE:  if (emit) state_nxt = S_IDLE;
      default: state_nxt = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      k_raw_r     <= K_W'(MAX_CLUSTERS);
      d_raw_r     <= D_W'(MAX_DIMS);
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CLEAR) clr_r <= clr_r + 1'b1;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_CLUSTERS) k_raw_r <= cfg_data;
        else if (cfg_index == REG_DIMS) d_raw_r <= cfg_data[D_W-1:0];
      end
      if (emit) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      act_r     <= in_data.action;
      pidx_r    <= in_data.point_index;
      res_idx_r <= in_data.centroid_index;
      dim_r     <= '0;
      for (int d = 0; d < MAX_DIMS; d++) pt_r[d] <= ld_vec[d];
      asg_q_r   <= asg_mem[in_data.point_index];
    end
    unique case (state_r)
      S_DIST: begin
        if (last_dim) wait_r <= WAIT_W'(DRAIN_CYC);
        else dim_r <= dim_r + 1'b1;
      end
      S_DRAIN: begin
        wait_r <= wait_r - 1'b1;
        if (wait_r == '0) res_idx_r <= chain[MAX_CLUSTERS].idx;
      end
      S_CNT: dim_r <= '0;
      S_MUL: prod_r <= win_coord * nm1;
      S_ADD: num_r  <= prod_r + NUM_W'($signed(pt_r[dim_r]));
      S_DIVW: if (div_done && !last_dim) dim_r <= dim_r + 1'b1;
      default: ;
    endcase
    if (state_r == S_CLEAR) begin
      asg_mem[clr_r] <= '0;
    end else if (emit && act_r == ACT_TRAIN) begin
      asg_mem[pidx_r] <= res_idx_r;
    end
    if (emit) begin
      out_r.cluster       <= (act_r == ACT_NOP) ? '0 : res_idx_r;
      out_r.changed       <= (act_r == ACT_TRAIN) && (asg_q_r != res_idx_r);
      out_r.cluster_count <= (act_r == ACT_NOP) ? '0 : sel_cnt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

[rtl/core/kmu_checker.sv]
`timescale 1ns / 1ps
// Port-level checks for online_kmeans_update, bound to the top level.
// Depends on kmu_pkg.
module kmu_checker import kmu_pkg::*; (
  input logic     clk,
  input logic     rst_n,
  input logic     in_valid,
  input logic     in_stall,
  input logic     out_valid,
  input logic     out_stall,
  input kmu_out_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result beat changed under stall");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second beat taken while busy");

  a_clear_after_reset: assert property (@(posedge clk)
    !rst_n |=> in_stall)
    else $error("input open during assignment clear");

  a_changed_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.changed |-> out_data.cluster_count != '0)
    else $error("changed beat with zero count");

endmodule

bind online_kmeans_update kmu_checker u_kmu_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
